FILE: rtl/gjr_pkg.sv
// Shared types, constants and saturation helpers for the Gauss-Jordan solver.
package gjr_pkg;

   localparam int Q_W                 = 32;
   localparam int DEF_MAX_ROWS        = 8;
   localparam int DEF_MAX_COLUMNS     = 8;
   localparam int DEF_FRACTION_BITS   = 16;
   localparam int CFG_W               = 4;
   localparam int CSR_INDEX_W         = 2;

   localparam logic [CFG_W-1:0] ROW_COUNT_RST    = 4'd3;
   localparam logic [CFG_W-1:0] COLUMN_COUNT_RST = 4'd4;

   localparam logic [CSR_INDEX_W-1:0] REG_ROW_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;

   localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [Q_W-1:0] element_value;
      logic                  last_element;
   } req_type;

   typedef struct packed {
      logic [2:0]            row_index;
      logic [2:0]            column_index;
      logic signed [Q_W-1:0] result_value;
      logic                  saturated;
      logic                  last_result;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic signed [Q_W-1:0] dividend;
      logic signed [Q_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic signed [Q_W-1:0] quotient;
      logic                  sat;
   } div_rsp_type;

   typedef struct packed {
      logic signed [Q_W-1:0] value;
      logic                  sat;
   } clamp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_F_COL,
      ST_F_SRCH,
      ST_F_SRCH_W,
      ST_SW_RA,
      ST_SW_RB,
      ST_SW_WA,
      ST_SW_WB,
      ST_E_K,
      ST_E_KW,
      ST_E_PV,
      ST_E_DIV,
      ST_J_RA,
      ST_J_RB,
      ST_J_MUL,
      ST_J_RND,
      ST_J_SUB,
      ST_B_K,
      ST_B_SR,
      ST_B_SRW,
      ST_S_RD,
      ST_S_ST,
      ST_S_DIV,
      ST_U_I,
      ST_U_IW,
      ST_O_RD,
      ST_O_WT
   } state_type;

   // Clamp a signed magnitude to the 32-bit range
   function automatic clamp_type q_clamp(input logic [63:0] mag, input logic neg);
      clamp_type res;
      res.sat = 1'b0;
      if (!neg) begin
         if (mag > 64'h0000_0000_7FFF_FFFF) begin
            res.value = Q_MAX;
            res.sat   = 1'b1;
         end else begin
            res.value = mag[Q_W-1:0];
         end
      end else begin
         if (mag > 64'h0000_0000_8000_0000) begin
            res.value = Q_MIN;
            res.sat   = 1'b1;
         end else begin
            res.value = ~mag[Q_W-1:0] + 32'd1;
         end
      end
      return res;
   endfunction

   // Exact subtract with clamp
   function automatic clamp_type q_sub(input logic signed [Q_W-1:0] a,
                                       input logic signed [Q_W-1:0] b);
      clamp_type    res;
      logic [Q_W:0] diff;
      diff = {a[Q_W-1], a} - {b[Q_W-1], b};
      res.sat = diff[Q_W] ^ diff[Q_W-1];
      if (res.sat) begin
         res.value = diff[Q_W] ? Q_MIN : Q_MAX;
      end else begin
         res.value = diff[Q_W-1:0];
      end
      return res;
   endfunction

endpackage

FILE: rtl/gjr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gjr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/gjr_div.sv
// Bit-serial restoring divider for rounded signed Q-format division.
module gjr_div #(
   parameter int FRACTION_BITS = gjr_pkg::DEF_FRACTION_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  gjr_pkg::div_req_type div_req,
   output gjr_pkg::div_rsp_type div_rsp
);

   localparam int NUM_W = gjr_pkg::Q_W + FRACTION_BITS + 1;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [NUM_W-1:0]       num_ff, num_in;
   logic [gjr_pkg::Q_W-1:0] rem_ff, rem_in;
   logic [gjr_pkg::Q_W-1:0] mb_ff, mb_in;
   logic                   neg_ff, neg_in;

   logic [gjr_pkg::Q_W-1:0] ma, mb;
   logic [gjr_pkg::Q_W:0]   trial;
   logic                   take;
   gjr_pkg::clamp_type     res;

   // Operand magnitudes
   always_comb begin
      ma = div_req.dividend[gjr_pkg::Q_W-1] ? (~div_req.dividend + 32'd1) : div_req.dividend;
      mb = div_req.divisor[gjr_pkg::Q_W-1] ? (~div_req.divisor + 32'd1) : div_req.divisor;
   end

   // One quotient bit per step
   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      take  = trial >= {1'b0, mb_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      if (busy_ff) begin
         rem_in = take ? 32'(trial - {1'b0, mb_ff}) : trial[gjr_pkg::Q_W-1:0];
         num_in = {num_ff[NUM_W-2:0], take};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         num_in  = (NUM_W'(ma) << FRACTION_BITS) + NUM_W'(mb >> 1);
         rem_in  = '0;
         mb_in   = mb;
         neg_in  = div_req.dividend[gjr_pkg::Q_W-1] ^ div_req.divisor[gjr_pkg::Q_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
   end

   // Apply sign and clamp
   always_comb begin
      res              = gjr_pkg::q_clamp(64'(num_ff), neg_ff);
      div_rsp.done     = done_ff;
      div_rsp.quotient = res.value;
      div_rsp.sat      = res.sat;
   end

endmodule

FILE: rtl/gauss_jordan_rref_solver_top.sv
// Top level of the Gauss-Jordan solver: load, reduce and emit sequencer.
//
// Usage: write row_count (index 0) and column_count (index 1) on the csr_
// channel while the block is idle; csr_ready is always high. Send the matrix
// on the req_ channel in row-major order, one entry per beat; entries past
// rows*columns are dropped. The beat with last_element set starts the solve.
// Loading takes one beat per cycle. The solve runs from one matrix memory
// with one read and one write port: each row update steps, per column,
// through a read of the target, a read of the source, a multiply, a round
// and a subtract with write-back, and each division holds the sequencer
// while the bit-serial divider runs. The solve time is bounded by that
// memory port and the divider, plus pivot search and row swaps. The reduced
// matrix then leaves on the rsp_ channel, row-major, each beat read from
// memory and then registered, with last_result on the final beat.
// req_ready is low from the last load beat until the final result has entered
// the output register; a stalled receiver holds that register and the
// sequencer. Loading of the next matrix may start while the final result
// waits. Reset returns the sequencer to idle, clears the load position and
// the saturation flag and sets the registers to 3 rows and 4 columns.
module gauss_jordan_rref_solver_top #(
   parameter int MAX_ROWS      = gjr_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLUMNS   = gjr_pkg::DEF_MAX_COLUMNS,
   parameter int FRACTION_BITS = gjr_pkg::DEF_FRACTION_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  gjr_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output gjr_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gjr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gjr_pkg::CFG_W-1:0]         csr_data
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
   localparam int AW     = $clog2(DEPTH);
   localparam int RW     = $clog2(MAX_ROWS + 1);
   localparam int CW     = $clog2(MAX_COLUMNS + 1);
   localparam int OUT_RW = (RW > 3) ? RW : 3;
   localparam int OUT_CW = (CW > 3) ? CW : 3;
   localparam int QW     = gjr_pkg::Q_W;

   gjr_pkg::state_type state_ff, state_in;

   logic [gjr_pkg::CFG_W-1:0] rows_cfg_ff, cols_cfg_ff;
   logic [RW-1:0]          r_ff, r_in, p_ff, p_in, k_ff, k_in, i_ff, i_in;
   logic [CW-1:0]          c_ff, c_in, j_ff, j_in;
   logic                   phase_ff, phase_in;
   logic signed [QW-1:0]   a_ff, a_in, x_ff, x_in, piv_ff, piv_in;
   logic signed [2*QW-1:0] prod_ff;
   logic signed [QW-1:0]   mres_ff;
   logic [AW:0]            load_pos_ff, load_pos_in, out_pos_ff, out_pos_in;
   logic [OUT_RW-1:0]      out_row_ff, out_row_in;
   logic [OUT_CW-1:0]      out_col_ff, out_col_in;
   logic                   ovf_ff, ovf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   gjr_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   logic [RW-1:0]          eff_rows;
   logic [CW-1:0]          eff_cols;
   logic [AW:0]            total;
   logic [RW-1:0]          tgt_row, src_row;

   logic                   wr_en, rd_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [QW-1:0]          wr_data, rd_data;
   logic signed [QW-1:0]   rd_val;
   logic                   sat_now;

   gjr_pkg::div_req_type   div_req;
   gjr_pkg::div_rsp_type   div_rsp;
   gjr_pkg::clamp_type     mul_c, sub_c;
   logic [2*QW-1:0]        mul_mag, mul_rnd;

   function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] row,
                                             input logic [CW-1:0] col,
                                             input logic [CW-1:0] cols);
      logic [RW+CW-1:0] t;
      t = (RW+CW)'(row) * (RW+CW)'(cols) + (RW+CW)'(col);
      return AW'(t);
   endfunction

   // Clamp the registers to their usable range
   always_comb begin
      if (rows_cfg_ff == '0) begin
         eff_rows = RW'(1);
      end else if (int'(rows_cfg_ff) > MAX_ROWS) begin
         eff_rows = RW'(MAX_ROWS);
      end else begin
         eff_rows = RW'(rows_cfg_ff);
      end
      if (cols_cfg_ff < 4'd2) begin
         eff_cols = CW'(2);
      end else if (int'(cols_cfg_ff) > MAX_COLUMNS) begin
         eff_cols = CW'(MAX_COLUMNS);
      end else begin
         eff_cols = CW'(cols_cfg_ff);
      end
      total = (AW+1)'((RW+CW)'(eff_rows) * (RW+CW)'(eff_cols));
   end

   assign tgt_row = phase_ff ? i_ff : k_ff;
   assign src_row = phase_ff ? k_ff : r_ff;
   assign rd_val  = rd_data;

   // Round and clamp the registered product, then subtract
   always_comb begin
      mul_mag = prod_ff[2*QW-1] ? (~prod_ff + 64'd1) : prod_ff;
      mul_rnd = (mul_mag + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
      mul_c   = gjr_pkg::q_clamp(mul_rnd, prod_ff[2*QW-1]);
      sub_c   = gjr_pkg::q_sub(a_ff, mres_ff);
   end

   // Next state and sequencer counters
   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      p_in         = p_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      c_in         = c_ff;
      j_in         = j_ff;
      phase_in     = phase_ff;
      a_in         = a_ff;
      x_in         = x_ff;
      piv_in       = piv_ff;
      load_pos_in  = load_pos_ff;
      out_pos_in   = out_pos_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      ovf_in       = ovf_ff | sat_now;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         gjr_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (load_pos_ff < total) begin
                  load_pos_in = load_pos_ff + (AW+1)'(1);
               end
               if (req_data.last_element) begin
                  load_pos_in = '0;
                  ovf_in      = 1'b0;
                  r_in        = '0;
                  c_in        = '0;
                  state_in    = gjr_pkg::ST_F_COL;
               end
            end
         end
         gjr_pkg::ST_F_COL: begin
            if (c_ff >= eff_cols || r_ff >= eff_rows) begin
               k_in     = eff_rows - RW'(1);
               phase_in = 1'b1;
               state_in = gjr_pkg::ST_B_K;
            end else begin
               p_in     = r_ff;
               state_in = gjr_pkg::ST_F_SRCH;
            end
         end
         gjr_pkg::ST_F_SRCH: state_in = gjr_pkg::ST_F_SRCH_W;
         gjr_pkg::ST_F_SRCH_W: begin
            if (rd_val != '0) begin
               j_in = '0;
               if (p_ff != r_ff) begin
                  state_in = gjr_pkg::ST_SW_RA;
               end else begin
                  k_in     = r_ff + RW'(1);
                  phase_in = 1'b0;
                  state_in = gjr_pkg::ST_E_K;
               end
            end else if (p_ff + RW'(1) >= eff_rows) begin
               c_in     = c_ff + CW'(1);
               state_in = gjr_pkg::ST_F_COL;
            end else begin
               p_in     = p_ff + RW'(1);
               state_in = gjr_pkg::ST_F_SRCH;
            end
         end
         gjr_pkg::ST_SW_RA: state_in = gjr_pkg::ST_SW_RB;
         gjr_pkg::ST_SW_RB: begin
            a_in     = rd_val;
            state_in = gjr_pkg::ST_SW_WA;
         end
         gjr_pkg::ST_SW_WA: state_in = gjr_pkg::ST_SW_WB;
         gjr_pkg::ST_SW_WB: begin
            j_in = j_ff + CW'(1);
            if (j_ff + CW'(1) == eff_cols) begin
               k_in     = r_ff + RW'(1);
               phase_in = 1'b0;
               state_in = gjr_pkg::ST_E_K;
            end else begin
               state_in = gjr_pkg::ST_SW_RA;
            end
         end
         gjr_pkg::ST_E_K: begin
            if (k_ff >= eff_rows) begin
               r_in     = r_ff + RW'(1);
               c_in     = c_ff + CW'(1);
               state_in = gjr_pkg::ST_F_COL;
            end else begin
               state_in = gjr_pkg::ST_E_KW;
            end
         end
         gjr_pkg::ST_E_KW: begin
            if (rd_val == '0) begin
               k_in     = k_ff + RW'(1);
               state_in = gjr_pkg::ST_E_K;
            end else begin
               a_in     = rd_val;
               state_in = gjr_pkg::ST_E_PV;
            end
         end
         gjr_pkg::ST_E_PV: state_in = gjr_pkg::ST_E_DIV;
         gjr_pkg::ST_E_DIV: begin
            if (div_rsp.done) begin
               x_in     = div_rsp.quotient;
               j_in     = '0;
               state_in = gjr_pkg::ST_J_RA;
            end
         end
         gjr_pkg::ST_J_RA: state_in = gjr_pkg::ST_J_RB;
         gjr_pkg::ST_J_RB: begin
            a_in     = rd_val;
            state_in = gjr_pkg::ST_J_MUL;
         end
         gjr_pkg::ST_J_MUL: state_in = gjr_pkg::ST_J_RND;
         gjr_pkg::ST_J_RND: state_in = gjr_pkg::ST_J_SUB;
         gjr_pkg::ST_J_SUB: begin
            j_in = j_ff + CW'(1);
            if (j_ff + CW'(1) == eff_cols) begin
               if (!phase_ff) begin
                  k_in     = k_ff + RW'(1);
                  state_in = gjr_pkg::ST_E_K;
               end else begin
                  i_in     = i_ff + RW'(1);
                  state_in = gjr_pkg::ST_U_I;
               end
            end else begin
               state_in = gjr_pkg::ST_J_RA;
            end
         end
         gjr_pkg::ST_B_K: begin
            c_in     = '0;
            state_in = gjr_pkg::ST_B_SR;
         end
         gjr_pkg::ST_B_SR: state_in = gjr_pkg::ST_B_SRW;
         gjr_pkg::ST_B_SRW: begin
            if (rd_val != '0) begin
               piv_in   = rd_val;
               j_in     = '0;
               state_in = gjr_pkg::ST_S_RD;
            end else if (c_ff + CW'(1) >= eff_cols - CW'(1)) begin
               if (k_ff == '0) begin
                  out_pos_in = '0;
                  out_row_in = '0;
                  out_col_in = '0;
                  state_in   = gjr_pkg::ST_O_RD;
               end else begin
                  k_in     = k_ff - RW'(1);
                  state_in = gjr_pkg::ST_B_K;
               end
            end else begin
               c_in     = c_ff + CW'(1);
               state_in = gjr_pkg::ST_B_SR;
            end
         end
         gjr_pkg::ST_S_RD: state_in = gjr_pkg::ST_S_ST;
         gjr_pkg::ST_S_ST: state_in = gjr_pkg::ST_S_DIV;
         gjr_pkg::ST_S_DIV: begin
            if (div_rsp.done) begin
               j_in = j_ff + CW'(1);
               if (j_ff + CW'(1) == eff_cols) begin
                  i_in     = '0;
                  state_in = gjr_pkg::ST_U_I;
               end else begin
                  state_in = gjr_pkg::ST_S_RD;
               end
            end
         end
         gjr_pkg::ST_U_I: begin
            if (i_ff >= k_ff) begin
               if (k_ff == '0) begin
                  out_pos_in = '0;
                  out_row_in = '0;
                  out_col_in = '0;
                  state_in   = gjr_pkg::ST_O_RD;
               end else begin
                  k_in     = k_ff - RW'(1);
                  state_in = gjr_pkg::ST_B_K;
               end
            end else begin
               state_in = gjr_pkg::ST_U_IW;
            end
         end
         gjr_pkg::ST_U_IW: begin
            if (rd_val == '0) begin
               i_in     = i_ff + RW'(1);
               state_in = gjr_pkg::ST_U_I;
            end else begin
               x_in     = rd_val;
               j_in     = '0;
               state_in = gjr_pkg::ST_J_RA;
            end
         end
         gjr_pkg::ST_O_RD: state_in = gjr_pkg::ST_O_WT;
         gjr_pkg::ST_O_WT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.row_index    = out_row_ff[2:0];
               rsp_data_in.column_index = out_col_ff[2:0];
               rsp_data_in.result_value = rd_val;
               rsp_data_in.saturated    = ovf_ff;
               rsp_data_in.last_result  = (out_pos_ff + (AW+1)'(1) == total);
               out_pos_in               = out_pos_ff + (AW+1)'(1);
               if (OUT_CW'(out_col_ff) + OUT_CW'(1) == OUT_CW'(eff_cols)) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + OUT_RW'(1);
               end else begin
                  out_col_in = out_col_ff + OUT_CW'(1);
               end
               if (out_pos_ff + (AW+1)'(1) == total) begin
                  state_in = gjr_pkg::ST_IDLE;
               end else begin
                  state_in = gjr_pkg::ST_O_RD;
               end
            end
         end
         default: state_in = gjr_pkg::ST_IDLE;
      endcase
   end

   // Memory ports, divider start and saturation events per state
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      sat_now = 1'b0;
      div_req = '0;
      unique case (state_ff)
         gjr_pkg::ST_IDLE: begin
            wr_en   = req_valid && (load_pos_ff < total);
            wr_addr = load_pos_ff[AW-1:0];
            wr_data = req_data.element_value;
         end
         gjr_pkg::ST_F_SRCH: begin
            rd_en   = 1'b1;
            rd_addr = addr_of(p_ff, c_ff, eff_cols);
         end
         gjr_pkg::ST_SW_RA: begin
            rd_en   = 1'b1;
            rd_addr = addr_of(p_ff, j_ff, eff_cols);
         end
         gjr_pkg::ST_SW_RB: begin
            rd_en   = 1'b1;
            rd_addr = addr_of(r_ff, j_ff, eff_cols);
         end
         gjr_pkg::ST_SW_WA: begin
            wr_en   = 1'b1;
            wr_addr = addr_of(p_ff, j_ff, eff_cols);
            wr_data = rd_val;
         end
         gjr_pkg::ST_SW_WB: begin
            wr_en   = 1'b1;
            wr_addr = addr_of(r_ff, j_ff, eff_cols);
            wr_data = a_ff;
         end
         gjr_pkg::ST_E_K: begin
            rd_en   = k_ff < eff_rows;
            rd_addr = addr_of(k_ff, c_ff, eff_cols);
         end
         gjr_pkg::ST_E_KW: begin
            rd_en   = 1'b1;
            rd_addr = addr_of(r_ff, c_ff, eff_cols);
         end
         gjr_pkg::ST_E_PV: begin
            div_req.start    = 1'b1;
            div_req.dividend = a_ff;
            div_req.divisor  = rd_val;
         end
         gjr_pkg::ST_E_DIV: begin
            sat_now = div_rsp.done & div_rsp.sat;
         end
         gjr_pkg::ST_J_RA: begin
            rd_en   = 1'b1;
            rd_addr = addr_of(tgt_row, j_ff, eff_cols);
         end
         gjr_pkg::ST_J_RB: begin
            rd_en   = 1'b1;
            rd_addr = addr_of(src_row, j_ff, eff_cols);
         end
         gjr_pkg::ST_J_RND: begin
            sat_now = mul_c.sat;
         end
         gjr_pkg::ST_J_SUB: begin
            wr_en   = 1'b1;
            wr_addr = addr_of(tgt_row, j_ff, eff_cols);
            wr_data = (!phase_ff && j_ff == c_ff) ? '0 : sub_c.value;
            sat_now = sub_c.sat;
         end
         gjr_pkg::ST_B_SR: begin
            rd_en   = 1'b1;
            rd_addr = addr_of(k_ff, c_ff, eff_cols);
         end
         gjr_pkg::ST_S_RD: begin
            rd_en   = 1'b1;
            rd_addr = addr_of(k_ff, j_ff, eff_cols);
         end
         gjr_pkg::ST_S_ST: begin
            div_req.start    = 1'b1;
            div_req.dividend = rd_val;
            div_req.divisor  = piv_ff;
         end
         gjr_pkg::ST_S_DIV: begin
            wr_en   = div_rsp.done;
            wr_addr = addr_of(k_ff, j_ff, eff_cols);
            wr_data = div_rsp.quotient;
            sat_now = div_rsp.done & div_rsp.sat;
         end
         gjr_pkg::ST_U_I: begin
            rd_en   = i_ff < k_ff;
            rd_addr = addr_of(i_ff, c_ff, eff_cols);
         end
         gjr_pkg::ST_O_RD: begin
            rd_en   = 1'b1;
            rd_addr = out_pos_ff[AW-1:0];
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // Control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gjr_pkg::ST_IDLE;
         load_pos_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rows_cfg_ff  <= gjr_pkg::ROW_COUNT_RST;
         cols_cfg_ff  <= gjr_pkg::COLUMN_COUNT_RST;
      end else begin
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_index == gjr_pkg::REG_ROW_COUNT) begin
            rows_cfg_ff <= csr_data;
         end
         if (csr_valid && csr_index == gjr_pkg::REG_COLUMN_COUNT) begin
            cols_cfg_ff <= csr_data;
         end
      end
      r_ff        <= r_in;
      p_ff        <= p_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      c_ff        <= c_in;
      j_ff        <= j_in;
      phase_ff    <= phase_in;
      a_ff        <= a_in;
      x_ff        <= x_in;
      piv_ff      <= piv_in;
      prod_ff     <= (2*QW)'(x_ff) * (2*QW)'(rd_val);
      mres_ff     <= mul_c.value;
      out_pos_ff  <= out_pos_in;
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
      rsp_data_ff <= rsp_data_in;
   end

   gjr_ram #(
      .WIDTH (QW),
      .DEPTH (DEPTH)
   ) u_matrix_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gjr_div #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready = (state_ff == gjr_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/gjr_checker.sv
// Port-level assertions for the Gauss-Jordan solver, bound to the top level.
module gjr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input gjr_pkg::req_type                req_data,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input gjr_pkg::rsp_type                rsp_data,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [gjr_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [gjr_pkg::CFG_W-1:0]       csr_data
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Drop results out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Stop loading once the last entry starts a solve
   a_solve_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_element |=> !req_ready)
      else $error("input taken right after last entry");

   // No loading while more results of the matrix are due
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_result |-> !req_ready)
      else $error("input taken during result emission");

   // Take every register beat with a known index and value
   a_csr_take: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready && !$isunknown({csr_index, csr_data}))
      else $error("register beat refused or unknown");

endmodule

bind gauss_jordan_rref_solver_top gjr_checker u_gjr_checker (.*);
